>>> hdl/dppm_pkg.sv
// Shared types and constants for the debounced pass period meter.
// No dependencies; every other file refers to this package by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package dppm_pkg;

    // Width of the wrapping tick counter used for elapsed time
    localparam int TIME_BITS    = 32;
    // Width of the internal pass counter
    localparam int COUNT_BITS   = 8;

    // Fixed field widths of the ports
    localparam int DIST_BITS    = 16;
    localparam int GOAL_BITS    = 8;
    localparam int TNOW_BITS    = 32;
    localparam int PERIOD_BITS  = 32;
    localparam int PC_BITS      = 8;
    localparam int CFG_IDX_BITS = 1;
    localparam int CFG_DATA_BITS = 16;

    // Serial divider step counter
    localparam int DIV_CNT_BITS = $clog2(TIME_BITS);

    // Job queue between front and back, power-of-two depth
    localparam int JQ_DEPTH     = 2;
    localparam int JQ_AW        = $clog2(JQ_DEPTH);

    // Reset values of the configuration registers
    localparam logic [DIST_BITS-1:0] NEAR_THRESHOLD_RST = 16'd8960;  // 35.0 in Q8.8
    localparam logic [GOAL_BITS-1:0] GOAL_PASSES_RST    = 8'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_NEAR_THRESHOLD = 1'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_GOAL_PASSES    = 1'd1;

    // Request codes
    localparam logic REQ_START  = 1'b0;
    localparam logic REQ_SAMPLE = 1'b1;

    typedef struct packed {
        logic                 req_type;
        logic [DIST_BITS-1:0] distance;
        logic [TNOW_BITS-1:0] time_now;
    } t_in_item;

    typedef struct packed {
        logic                   period_valid;
        logic [PERIOD_BITS-1:0] period_ticks;
        logic [PC_BITS-1:0]     pass_count;
        logic                   measuring;
    } t_out_item;

    // Work handed from the front to the back
    typedef struct packed {
        logic                 need_div;
        logic [TIME_BITS-1:0] elapsed;
        logic [GOAL_BITS-1:0] goal;
        logic [PC_BITS-1:0]   pass_count;
        logic                 measuring;
    } t_job;

endpackage

`default_nettype wire

>>> hdl/dppm_front.sv
// Front end: configuration registers, debounce state and pass counting.
// Turns each transferred item into one job for the back end. Uses dppm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dppm_front (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_accept,
    input  wire dppm_pkg::t_in_item                   i_item,
    input  wire logic                                 i_cfg_we,
    input  wire logic [dppm_pkg::CFG_IDX_BITS-1:0]    i_cfg_idx,
    input  wire logic [dppm_pkg::CFG_DATA_BITS-1:0]   i_cfg_wdata,
    output dppm_pkg::t_job                            o_job
);

    logic [dppm_pkg::DIST_BITS-1:0]  r_near_threshold;
    logic [dppm_pkg::GOAL_BITS-1:0]  r_goal_passes;

    logic                            r_measuring, n_measuring;
    logic                            r_found, n_found;
    logic                            r_started, n_started;
    logic [3:0]                      r_near_run, n_near_run;
    logic [3:0]                      r_away_run, n_away_run;
    logic [dppm_pkg::COUNT_BITS-1:0] r_passes, n_passes;
    logic [dppm_pkg::TIME_BITS-1:0]  r_start_time, n_start_time;

    logic [dppm_pkg::TIME_BITS-1:0]  now;
    logic [dppm_pkg::TIME_BITS+dppm_pkg::TNOW_BITS-1:0] now_ext;
    logic [dppm_pkg::COUNT_BITS+dppm_pkg::PC_BITS-1:0]  pc_ext;
    logic                            need_div;

    // Fit the port tick count to the internal time width
    assign now_ext = {{dppm_pkg::TIME_BITS{1'b0}}, i_item.time_now};
    assign now     = now_ext[dppm_pkg::TIME_BITS-1:0];

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_near_threshold <= dppm_pkg::NEAR_THRESHOLD_RST;
            r_goal_passes    <= dppm_pkg::GOAL_PASSES_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                dppm_pkg::REG_NEAR_THRESHOLD: r_near_threshold <= i_cfg_wdata;
                dppm_pkg::REG_GOAL_PASSES:
                    r_goal_passes <= i_cfg_wdata[dppm_pkg::GOAL_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Advance the debounce state for one item
    always_comb begin
        logic       near_hit;
        logic       far_hit;
        logic       n3;
        logic [3:0] old_near;
        logic [3:0] old_away;
        n_measuring  = r_measuring;
        n_found      = r_found;
        n_started    = r_started;
        n_near_run   = r_near_run;
        n_away_run   = r_away_run;
        n_passes     = r_passes;
        n_start_time = r_start_time;
        need_div     = 1'b0;
        near_hit     = (i_item.distance <= r_near_threshold);
        far_hit      = (i_item.distance >= r_near_threshold);
        old_near     = r_near_run;
        old_away     = r_away_run;
        n3           = old_near[2];

        if (i_item.req_type == dppm_pkg::REQ_START) begin
            n_measuring = 1'b1;
            n_found     = 1'b0;
            n_started   = 1'b0;
            n_near_run  = 4'd0;
            n_away_run  = 4'd0;
            n_passes    = '0;
        end else if (r_measuring) begin
            // Near side: count a pass once the away run has qualified
            if (near_hit && !r_found) begin
                if (r_away_run[3] && n3) begin
                    n_passes   = r_passes + 1'b1;
                    n_away_run = 4'd0;
                    if ((r_goal_passes != '0) &&
                        ({{dppm_pkg::GOAL_BITS{1'b0}}, n_passes} ==
                         {{dppm_pkg::COUNT_BITS{1'b0}}, r_goal_passes})) begin
                        need_div    = 1'b1;
                        n_found     = 1'b1;
                        n_measuring = 1'b0;
                    end
                end
                if (n3 && !r_started) begin
                    n_start_time = now;
                    n_started    = 1'b1;
                end
                n_near_run = {old_near[3] | n3, old_near[1:0], 1'b1};
            end else begin
                n_near_run = {r_near_run[3], 3'b000};
            end

            // Away side: runs only after the near run has qualified
            old_away = n_away_run;
            if (n_near_run[3] && !n_found) begin
                if (far_hit && old_away[2]) begin
                    old_away[3] = 1'b1;
                    n_near_run  = 4'd0;
                end
                n_away_run = {old_away[3], old_away[1:0], 1'b1};
            end else begin
                n_away_run = {old_away[3], 3'b000};
            end
        end
    end

    // Hold state between items
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_measuring  <= 1'b0;
            r_found      <= 1'b0;
            r_started    <= 1'b0;
            r_near_run   <= 4'd0;
            r_away_run   <= 4'd0;
            r_passes     <= '0;
            r_start_time <= '0;
        end else if (i_accept) begin
            r_measuring  <= n_measuring;
            r_found      <= n_found;
            r_started    <= n_started;
            r_near_run   <= n_near_run;
            r_away_run   <= n_away_run;
            r_passes     <= n_passes;
            r_start_time <= n_start_time;
        end
    end

    // Build the job for the back end
    assign pc_ext = {{dppm_pkg::PC_BITS{1'b0}}, n_passes};

    always_comb begin
        o_job.need_div   = need_div;
        o_job.elapsed    = now - r_start_time;
        o_job.goal       = r_goal_passes;
        o_job.pass_count = pc_ext[dppm_pkg::PC_BITS-1:0];
        o_job.measuring  = n_measuring;
    end

    // A completed goal ends the measurement
    a_goal_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && o_job.need_div) |=> (!r_measuring && r_found))
        else $error("goal reached but measurement still running");

endmodule

`default_nettype wire

>>> hdl/dppm_jobq.sv
// Short job queue between the front end and the back end.
// Register-based FIFO of dppm_pkg::t_job entries. Uses dppm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dppm_jobq (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire dppm_pkg::t_job i_job,
    output logic                o_full,
    input  wire logic           i_pop,
    output logic                o_empty,
    output dppm_pkg::t_job      o_job
);

    dppm_pkg::t_job              r_mem [dppm_pkg::JQ_DEPTH];
    logic [dppm_pkg::JQ_AW-1:0]  r_wr_ptr;
    logic [dppm_pkg::JQ_AW-1:0]  r_rd_ptr;
    logic [dppm_pkg::JQ_AW:0]    r_count;
    logic                        do_push;
    logic                        do_pop;

    assign o_full  = (r_count == (dppm_pkg::JQ_AW+1)'(dppm_pkg::JQ_DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_job   = r_mem[r_rd_ptr];

    // Store entries
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: ;
            endcase
        end
    end

    // Fill count stays in range
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (dppm_pkg::JQ_AW+1)'(dppm_pkg::JQ_DEPTH))
        else $error("job queue count out of range");

endmodule

`default_nettype wire

>>> hdl/dppm_back.sv
// Back end: radix-2 serial divider for the period and the result register.
// Takes jobs from dppm_jobq and presents results queue-style. Uses dppm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dppm_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_job_valid,
    input  wire dppm_pkg::t_job i_job,
    output logic                o_job_pop,
    input  wire logic           i_pop,
    output logic                o_empty,
    output dppm_pkg::t_out_item o_item
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_DONE = 3'b100
    } t_back_state;

    t_back_state                       r_state, n_state;
    logic                              r_out_valid, n_out_valid;
    dppm_pkg::t_out_item               r_out, n_out;
    logic [dppm_pkg::TIME_BITS-1:0]    r_dvd, n_dvd;
    logic [dppm_pkg::GOAL_BITS-1:0]    r_rem, n_rem;
    logic [dppm_pkg::GOAL_BITS-1:0]    r_goal, n_goal;
    logic [dppm_pkg::PC_BITS-1:0]      r_pc, n_pc;
    logic                              r_meas, n_meas;
    logic [dppm_pkg::DIV_CNT_BITS-1:0] r_cnt, n_cnt;

    logic                              slot_free;
    logic [dppm_pkg::GOAL_BITS:0]      trial;
    logic [dppm_pkg::GOAL_BITS:0]      diff;
    logic                              q_bit;
    logic [dppm_pkg::TIME_BITS+dppm_pkg::PERIOD_BITS-1:0] q_ext;
    logic [dppm_pkg::PERIOD_BITS-1:0]  period_sat;

    assign slot_free = !r_out_valid || i_pop;

    // One restoring division step
    assign trial = {r_rem, r_dvd[dppm_pkg::TIME_BITS-1]};
    assign diff  = trial - {1'b0, r_goal};
    assign q_bit = (trial >= {1'b0, r_goal});

    // Saturate the quotient to the period field
    assign q_ext      = {{dppm_pkg::PERIOD_BITS{1'b0}}, r_dvd};
    assign period_sat = (|(q_ext >> dppm_pkg::PERIOD_BITS)) ? '1
                                                            : q_ext[dppm_pkg::PERIOD_BITS-1:0];

    // Sequence jobs through the divider and into the result register
    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        n_dvd       = r_dvd;
        n_rem       = r_rem;
        n_goal      = r_goal;
        n_pc        = r_pc;
        n_meas      = r_meas;
        n_cnt       = r_cnt;
        o_job_pop   = 1'b0;

        if (i_pop && r_out_valid) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (i_job_valid) begin
                    if (i_job.need_div) begin
                        o_job_pop = 1'b1;
                        n_dvd     = i_job.elapsed;
                        n_rem     = '0;
                        n_goal    = i_job.goal;
                        n_pc      = i_job.pass_count;
                        n_meas    = i_job.measuring;
                        n_cnt     = dppm_pkg::DIV_CNT_BITS'(dppm_pkg::TIME_BITS - 1);
                        n_state   = ST_DIV;
                    end else if (slot_free) begin
                        o_job_pop          = 1'b1;
                        n_out.period_valid = 1'b0;
                        n_out.period_ticks = '0;
                        n_out.pass_count   = i_job.pass_count;
                        n_out.measuring    = i_job.measuring;
                        n_out_valid        = 1'b1;
                    end
                end
            end
            ST_DIV: begin
                n_rem = q_bit ? diff[dppm_pkg::GOAL_BITS-1:0]
                              : trial[dppm_pkg::GOAL_BITS-1:0];
                n_dvd = {r_dvd[dppm_pkg::TIME_BITS-2:0], q_bit};
                if (r_cnt == '0) begin
                    n_state = ST_DONE;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            ST_DONE: begin
                if (slot_free) begin
                    n_out.period_valid = 1'b1;
                    n_out.period_ticks = period_sat;
                    n_out.pass_count   = r_pc;
                    n_out.measuring    = r_meas;
                    n_out_valid        = 1'b1;
                    n_state            = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_dvd  <= n_dvd;
        r_rem  <= n_rem;
        r_goal <= n_goal;
        r_pc   <= n_pc;
        r_meas <= n_meas;
        r_cnt  <= n_cnt;
    end

    assign o_empty = !r_out_valid;
    assign o_item  = r_out;

    // Division finishes only after the last step
    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV && n_state == ST_DONE) |-> (r_cnt == '0))
        else $error("divider left before its last step");

    // A reported period always ends the measurement
    a_period_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.period_valid) |-> !r_out.measuring)
        else $error("period reported while still measuring");

    // No job is taken while the divider is busy
    a_no_pop_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !o_job_pop)
        else $error("job taken while divider busy");

endmodule

`default_nettype wire

>>> hdl/debounced_pass_period_meter.sv
// Top level of the debounced pass period meter: front end, job queue, back end.
// Depends on dppm_pkg, dppm_front, dppm_jobq and dppm_back.
// Usage: push a start request (req_type 0), then timestamped distance samples
// (req_type 1); every item yields exactly one result. The front end takes one
// item per cycle while the job queue is not full and hands a job to a two-entry
// queue. Results that carry no period are registered in the back end's result
// register once the divider is idle and that register is free. A result that
// completes the goal runs through a radix-2 serial divider, one quotient bit
// per cycle; items behind it wait in the queue and full rises when it fills.
// Configuration writes take effect on the next cycle and are meant for idle
// periods only.
`timescale 1ns / 1ps
`default_nettype none

module debounced_pass_period_meter (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 push,
    output logic                                      full,
    input  wire dppm_pkg::t_in_item                   i_item,
    output logic                                      empty,
    input  wire logic                                 pop,
    output dppm_pkg::t_out_item                       o_item,
    input  wire logic                                 i_cfg_we,
    input  wire logic [dppm_pkg::CFG_IDX_BITS-1:0]    i_cfg_idx,
    input  wire logic [dppm_pkg::CFG_DATA_BITS-1:0]   i_cfg_wdata
);

    dppm_pkg::t_job front_job;
    dppm_pkg::t_job head_job;
    logic           jq_full;
    logic           jq_empty;
    logic           jq_pop;
    logic           accept;

    // Transfer on push while the queue has room
    assign accept = push && !jq_full;
    assign full   = jq_full;

    dppm_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_item      (i_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_job       (front_job)
    );

    dppm_jobq u_jobq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_job   (front_job),
        .o_full  (jq_full),
        .i_pop   (jq_pop),
        .o_empty (jq_empty),
        .o_job   (head_job)
    );

    dppm_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (!jq_empty),
        .i_job       (head_job),
        .o_job_pop   (jq_pop),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_item      (o_item)
    );

endmodule

`default_nettype wire

>>> sim/testbench.sv
// Self-checking testbench for debounced_pass_period_meter: drives start and distance
// transfers, predicts each result in step with the stimulus and compares field by field.
// Depends on dppm_pkg and the meter RTL only.
`timescale 1ns / 1ps

module testbench;

    localparam int SAMPLE_TARGET = 1350;
    localparam int STALL_LIMIT   = 2000;   // cycles with no transfer on either side
    localparam int DRAIN_GAP     = 40;     // covers the serial divider of the back end
    localparam int LONG_HOLD     = 300;    // receiver hold-off that fills the block

    logic                               i_clk;
    logic                               i_rst_n;
    logic                               push;
    logic                               full;
    dppm_pkg::t_in_item                 i_item;
    logic                               empty;
    logic                               pop;
    dppm_pkg::t_out_item                o_item;
    logic                               i_cfg_we;
    logic [dppm_pkg::CFG_IDX_BITS-1:0]  i_cfg_idx;
    logic [dppm_pkg::CFG_DATA_BITS-1:0] i_cfg_wdata;

    // Register copies and meter state tracked by the predictor
    logic [dppm_pkg::DIST_BITS-1:0]     thr_q;
    logic [dppm_pkg::GOAL_BITS-1:0]     goal_q;
    logic                               meter_on;
    logic                               period_found;
    logic                               t0_taken;
    logic [3:0]                         near_hist;
    logic [3:0]                         away_hist;
    logic [dppm_pkg::COUNT_BITS-1:0]    pass_tally;
    logic [dppm_pkg::TIME_BITS-1:0]     t0;

    dppm_pkg::t_out_item                meter_results_q[$];
    int                                 fail_count = 0;
    int                                 counted_items = 0;
    int                                 stall_cycles = 0;
    logic [dppm_pkg::TNOW_BITS-1:0]     tick;
    bit                                 steady;
    bit                                 hold_request;

    debounced_pass_period_meter DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_item      (i_item),
        .empty       (empty),
        .pop         (pop),
        .o_item      (o_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Advance the debounce runs and pass count by one item; return the result it yields
    function automatic dppm_pkg::t_out_item meter_step(input dppm_pkg::t_in_item it);
        dppm_pkg::t_out_item            r;
        logic [3:0]                     h;
        logic                           n3;
        logic [dppm_pkg::TIME_BITS-1:0] elapsed;
        r = '0;
        if (it.req_type == dppm_pkg::REQ_START) begin
            meter_on     = 1'b1;
            period_found = 1'b0;
            t0_taken     = 1'b0;
            near_hist    = '0;
            away_hist    = '0;
            pass_tally   = '0;
        end else if (meter_on) begin
            if (it.distance <= thr_q && !period_found) begin
                h  = near_hist;
                n3 = h[2];
                // a qualified away run followed by a full near run is one pass
                if (away_hist[3] && n3) begin
                    pass_tally = pass_tally + 1'b1;
                    away_hist  = '0;
                    if (goal_q != 0 && pass_tally == goal_q) begin
                        elapsed         = it.time_now - t0;
                        r.period_ticks  = elapsed / 32'(goal_q);
                        r.period_valid  = 1'b1;
                        period_found    = 1'b1;
                        meter_on        = 1'b0;
                    end
                end
                if (n3 && !t0_taken) begin
                    t0       = it.time_now;
                    t0_taken = 1'b1;
                end
                near_hist = {h[3] | n3, h[1:0], 1'b1};
            end else begin
                near_hist[2:0] = 3'b000;
            end
            // count away samples once the near run has qualified
            if (near_hist[3] && !period_found) begin
                h = away_hist;
                if (it.distance >= thr_q && h[2]) begin
                    h[3]      = 1'b1;
                    near_hist = '0;
                end
                away_hist = {h[3], h[1:0], 1'b1};
            end else begin
                away_hist[2:0] = 3'b000;
            end
        end
        r.pass_count = dppm_pkg::PC_BITS'(pass_tally);
        r.measuring  = meter_on;
        return r;
    endfunction

    // Offer one item, hold it until the transfer, then record its expected result
    task automatic send_item(input dppm_pkg::t_in_item it);
        if (!steady && $urandom_range(0, 99) < 9) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push   <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (full);
        counted_items++;
        meter_results_q.push_back(meter_step(it));
    endtask

    task automatic send_sample(input logic [dppm_pkg::DIST_BITS-1:0] sample_dist);
        dppm_pkg::t_in_item it;
        tick        = tick + $urandom_range(1, 250);
        it.req_type = dppm_pkg::REQ_SAMPLE;
        it.distance = sample_dist;
        it.time_now = tick;
        send_item(it);
    endtask

    task automatic send_start();
        dppm_pkg::t_in_item it;
        it.req_type = dppm_pkg::REQ_START;
        it.distance = dppm_pkg::DIST_BITS'($urandom);
        it.time_now = $urandom;
        send_item(it);
    endtask

    // Pick a near or far distance for the current threshold, often exactly on it
    function automatic logic [dppm_pkg::DIST_BITS-1:0] pick_dist(input bit go_near);
        if ($urandom_range(0, 6) == 0)
            return thr_q;
        if (go_near)
            return dppm_pkg::DIST_BITS'($urandom_range(0, thr_q));
        return dppm_pkg::DIST_BITS'($urandom_range(thr_q, 16'hFFFF));
    endfunction

    task automatic send_samples(input int n, input bit go_near, input int noise_pct);
        repeat (n) begin
            if ($urandom_range(0, 99) < noise_pct)
                send_sample(dppm_pkg::DIST_BITS'($urandom));
            else
                send_sample(pick_dist(go_near));
        end
    endtask

    // Start a measurement and walk it through n well-formed passes
    task automatic measure_passes(input int n, input int noise_pct);
        send_start();
        send_samples(4, 1'b1, noise_pct);
        repeat (n) begin
            send_samples($urandom_range(4, 6), 1'b0, noise_pct);
            send_samples(4, 1'b1, noise_pct);
        end
    endtask

    // Drop push and let every expected result and the divider drain
    task automatic wait_drained();
        push <= 1'b0;
        while (meter_results_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_GAP) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [dppm_pkg::CFG_IDX_BITS-1:0] idx,
                             input logic [dppm_pkg::CFG_DATA_BITS-1:0] val);
        wait_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        if (idx == dppm_pkg::REG_NEAR_THRESHOLD)
            thr_q = val;
        else
            goal_q = val[dppm_pkg::GOAL_BITS-1:0];
        @(posedge i_clk);
    endtask

    // Idle samples, threshold-equal samples and a restart under reset values
    task automatic test_idle_and_restart();
        send_sample(16'h0000);
        send_sample(16'hFFFF);
        send_start();
        send_sample(16'h0000);
        send_sample(dppm_pkg::NEAR_THRESHOLD_RST);
        send_sample(16'hFFFF);
        send_start();
        send_sample(dppm_pkg::NEAR_THRESHOLD_RST);
        send_sample(16'h0000);
    endtask

    // One full pass with a goal of one while the tick counter wraps
    task automatic test_single_pass_wrap();
        write_reg(dppm_pkg::REG_GOAL_PASSES, 16'd1);
        tick = 32'hFFFF_FF00;
        send_start();
        send_sample(16'h0000);
        send_sample(thr_q);
        send_sample(16'h0001);
        send_sample(thr_q);
        send_sample(16'hFFFF);
        send_sample(thr_q + 1'b1);
        send_sample(16'h8000);
        send_sample(thr_q);
        send_sample(thr_q - 1'b1);
        send_sample(16'h0000);
        send_sample(16'h0000);
        send_sample(thr_q);
    endtask

    task automatic test_threshold_extremes();
        steady = 1'b1;
        write_reg(dppm_pkg::REG_GOAL_PASSES, 16'd2);
        write_reg(dppm_pkg::REG_NEAR_THRESHOLD, 16'h0000);
        measure_passes(3, 0);
        write_reg(dppm_pkg::REG_NEAR_THRESHOLD, 16'hFFFF);
        measure_passes(3, 0);
        steady = 1'b0;
        write_reg(dppm_pkg::REG_NEAR_THRESHOLD, dppm_pkg::NEAR_THRESHOLD_RST);
    endtask

    task automatic test_goal_extremes();
        write_reg(dppm_pkg::REG_GOAL_PASSES, 16'd0);
        measure_passes(12, 0);
        write_reg(dppm_pkg::REG_GOAL_PASSES, 16'd255);
        measure_passes(20, 0);
        write_reg(dppm_pkg::REG_GOAL_PASSES, 16'd1);
        measure_passes(2, 0);
    endtask

    // Hold the receiver off long enough for full to rise and stall the sender
    task automatic test_backpressure();
        write_reg(dppm_pkg::REG_GOAL_PASSES, 16'd1);
        hold_request = 1'b1;
        repeat (6) measure_passes(1, 0);
    endtask

    task automatic test_random_traffic();
        int roll;
        int pick;
        int n;
        while (counted_items < SAMPLE_TARGET) begin
            roll = $urandom_range(0, 99);
            if (roll < 10) begin
                if ($urandom_range(0, 3) == 0)
                    write_reg(dppm_pkg::REG_NEAR_THRESHOLD,
                              dppm_pkg::CFG_DATA_BITS'($urandom));
                else
                    write_reg(dppm_pkg::REG_NEAR_THRESHOLD,
                              dppm_pkg::CFG_DATA_BITS'($urandom_range(2000, 20000)));
                pick = $urandom_range(0, 19);
                if (pick < 12)
                    write_reg(dppm_pkg::REG_GOAL_PASSES,
                              dppm_pkg::CFG_DATA_BITS'($urandom_range(1, 4)));
                else if (pick < 18)
                    write_reg(dppm_pkg::REG_GOAL_PASSES,
                              dppm_pkg::CFG_DATA_BITS'($urandom_range(5, 12)));
                else if (pick == 18)
                    write_reg(dppm_pkg::REG_GOAL_PASSES, 16'd0);
                else
                    write_reg(dppm_pkg::REG_GOAL_PASSES,
                              dppm_pkg::CFG_DATA_BITS'($urandom_range(13, 40)));
            end
            steady = ($urandom_range(0, 7) == 0);
            // noise with a jump of the tick counter
            if (roll >= 90) begin
                tick = $urandom;
                repeat ($urandom_range(1, 6)) send_sample(dppm_pkg::DIST_BITS'($urandom));
            end
            n = (goal_q == 0) ? $urandom_range(1, 5) : $urandom_range(1, goal_q + 1);
            measure_passes(n, (roll < 30) ? 15 : 0);
            steady = 1'b0;
        end
    endtask

    initial begin
        i_rst_n      = 1'b0;
        push         = 1'b0;
        i_item       = '0;
        i_cfg_we     = 1'b0;
        i_cfg_idx    = '0;
        i_cfg_wdata  = '0;
        steady       = 1'b0;
        hold_request = 1'b0;
        tick         = $urandom;
        thr_q        = dppm_pkg::NEAR_THRESHOLD_RST;
        goal_q       = dppm_pkg::GOAL_PASSES_RST;
        meter_on     = 1'b0;
        period_found = 1'b0;
        t0_taken     = 1'b0;
        near_hist    = '0;
        away_hist    = '0;
        pass_tally   = '0;
        t0           = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_idle_and_restart();
        test_single_pass_wrap();
        test_threshold_extremes();
        test_goal_extremes();
        test_backpressure();
        test_random_traffic();
        wait_drained();
        if (fail_count == 0)
            $display("[debounced_pass_period_meter] OK");
        else
            $display("[debounced_pass_period_meter] ERROR");
        $finish;
    end

    // Check each result transfer against the oldest expectation, then drive pop
    initial begin : result_sink
        int                  hold_left;
        dppm_pkg::t_out_item want;
        hold_left = 0;
        pop = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && pop && !empty) begin
                if (meter_results_q.size() == 0) begin
                    $error("result with nothing expected: %p", o_item);
                    fail_count++;
                end else begin
                    want = meter_results_q.pop_front();
                    if (o_item.period_valid !== want.period_valid) begin
                        $error("period_valid: expected %0d, got %0d",
                               want.period_valid, o_item.period_valid);
                        fail_count++;
                    end
                    if (o_item.period_ticks !== want.period_ticks) begin
                        $error("period_ticks: expected %0d, got %0d",
                               want.period_ticks, o_item.period_ticks);
                        fail_count++;
                    end
                    if (o_item.pass_count !== want.pass_count) begin
                        $error("pass_count: expected %0d, got %0d",
                               want.pass_count, o_item.pass_count);
                        fail_count++;
                    end
                    if (o_item.measuring !== want.measuring) begin
                        $error("measuring: expected %0d, got %0d",
                               want.measuring, o_item.measuring);
                        fail_count++;
                    end
                end
            end
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = LONG_HOLD;
            end
            if (!i_rst_n || hold_left > 0) begin
                pop <= 1'b0;
                if (hold_left > 0)
                    hold_left--;
            end else begin
                pop <= steady || ($urandom_range(0, 99) >= 9);
            end
        end
    end

    // End the run when neither side has moved for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("[debounced_pass_period_meter] ERROR");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

endmodule
